FILE: design/cht_pkg.sv
// Shared constants and codes for the coalesced hash table unit.
`default_nettype none
package cht_pkg;
   // default sizing
   localparam int SLOTS_DEF      = 64;
   localparam int VALUE_BITS_DEF = 32;

   // fixed field widths
   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 32;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_GET = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEL = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd3;
endpackage
`default_nettype wire

FILE: design/coalesced_hash_table_unit.sv
// Coalesced chained scatter hash table: get, set and delete on integer keys.
//
//   channel | direction | fields
//   req_    | in        | func, key, value
//   rsp_    | out       | status, value_out
//
// One word at a time passes through a small sequencer; each chain step is a
// read on the single registered read port of the slot memories and a compare.
// A get or delete walks the chain from the main position; a delete that hits
// a head with a successor refills the head from it; a set into a taken main
// position relinks a free slot, or moves a foreign entry out and walks its
// chain. A non power of two SLOTS reduces the main position 4 key bits a cycle.
// Reset (synchronous) clears the used bits, state and response valid only; a
// result waits in its output register while rsp_stall holds it.
`default_nettype none
module coalesced_hash_table_unit #(
   parameter int SLOTS      = cht_pkg::SLOTS_DEF,
   parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cht_pkg::FUNC_W-1:0]    req_func,
   input  logic [cht_pkg::KEY_W-1:0]     req_key,
   input  logic [cht_pkg::DATA_W-1:0]    req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cht_pkg::STATUS_W-1:0]  rsp_status,
   output logic [cht_pkg::DATA_W-1:0]    rsp_value_out
);
   import cht_pkg::*;

   localparam int IDXW = $clog2(SLOTS);
   localparam int LW   = $clog2(SLOTS + 1);
   localparam int VB   = VALUE_BITS;
   localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
   localparam logic [LW-1:0] END_LINK = LW'(SLOTS);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MOD  = 4'd1;
   localparam logic [3:0] ST_RD   = 4'd2;
   localparam logic [3:0] ST_CMP  = 4'd3;
   localparam logic [3:0] ST_DRD  = 4'd4;
   localparam logic [3:0] ST_DCPY = 4'd5;
   localparam logic [3:0] ST_SRD  = 4'd6;
   localparam logic [3:0] ST_SMP  = 4'd7;
   localparam logic [3:0] ST_SLNK = 4'd8;
   localparam logic [3:0] ST_WRD  = 4'd9;
   localparam logic [3:0] ST_WCMP = 4'd10;
   localparam logic [3:0] ST_SMPW = 4'd11;
   localparam logic [3:0] ST_FIN  = 4'd12;

   // slot memories
   logic [KEY_W-1:0] key_mem  [SLOTS];
   logic [VB-1:0]    val_mem  [SLOTS];
   logic [IDXW-1:0]  home_mem [SLOTS];
   logic [LW-1:0]    link_mem [SLOTS];

   logic [KEY_W-1:0] q_key;
   logic [VB-1:0]    q_val;
   logic [IDXW-1:0]  q_home;
   logic [LW-1:0]    q_link;

   logic [3:0]          state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VB-1:0]       val_ff, val_in;
   logic [IDXW-1:0]     mp_ff, mp_in;
   logic [LW-1:0]       addr_ff, addr_in;
   logic [LW-1:0]       prev_ff, prev_in;
   logic [IDXW-1:0]     hit_ff, hit_in;
   logic [IDXW-1:0]     fr_ff, fr_in;
   logic [IDXW-1:0]     r_ff, r_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0]   vout_ff, vout_in;
   logic [SLOTS-1:0]    used_ff, used_in;
   logic [IDXW-1:0]     free_ff, free_in;
   logic                full_ff, full_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;

   // memory write controls
   logic                ent_we, val_we, link_we;
   logic [IDXW-1:0]     ent_addr, link_addr;
   logic [KEY_W-1:0]    ent_key;
   logic [IDXW-1:0]     ent_home;
   logic [VB-1:0]       ent_val;
   logic [LW-1:0]       link_data;
   logic                used_set, used_clr;
   logic [IDXW-1:0]     used_idx;

   logic [IDXW-1:0]     cur_idx;
   logic                cur_end;
   logic [IDXW+3:0]     mod_t, mod_r;
   logic [63:0]         req_val64, q_val64;

   assign cur_idx   = addr_ff[IDXW-1:0];
   assign cur_end   = (addr_ff == END_LINK);
   assign req_val64 = {32'b0, req_value};
   assign q_val64   = 64'(q_val);

   // reduce the main position four key bits a cycle
   always_comb begin
      mod_t = {r_ff, key_ff[{3'(3'd7 - cnt_ff), 2'b00} +: 4]};
      mod_r = mod_t;
      for (int k = 1; k < 16; k++) begin
         if (mod_t >= (IDXW+4)'(k * SLOTS)) begin
            mod_r = mod_t - (IDXW+4)'(k * SLOTS);
         end
      end
   end

   // pick the lowest free slot
   always_comb begin
      free_in = '0;
      full_in = &used_ff;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_in = IDXW'(i);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      mp_in     = mp_ff;
      addr_in   = addr_ff;
      prev_in   = prev_ff;
      hit_in    = hit_ff;
      fr_in     = fr_ff;
      r_in      = r_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      vout_in   = vout_ff;
      ent_we    = 1'b0;
      val_we    = 1'b0;
      link_we   = 1'b0;
      ent_addr  = mp_ff;
      link_addr = mp_ff;
      ent_key   = key_ff;
      ent_home  = mp_ff;
      ent_val   = val_ff;
      link_data = END_LINK;
      used_set  = 1'b0;
      used_clr  = 1'b0;
      used_idx  = cur_idx;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in   = req_func;
               key_in    = req_key;
               val_in    = req_val64[VB-1:0];
               prev_in   = END_LINK;
               status_in = STATUS_MISS;
               vout_in   = '0;
               r_in      = '0;
               cnt_in    = '0;
               if (POW2) begin
                  mp_in    = req_key[IDXW-1:0];
                  addr_in  = LW'(req_key[IDXW-1:0]);
                  state_in = ST_RD;
               end else begin
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            r_in   = mod_r[IDXW-1:0];
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               mp_in    = mod_r[IDXW-1:0];
               addr_in  = LW'(mod_r[IDXW-1:0]);
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            if (cur_end || !used_ff[cur_idx]) begin
               // key absent
               state_in = ST_FIN;
               if (func_ff == FUNC_SET) begin
                  if (full_ff) begin
                     status_in = STATUS_FULL;
                  end else if (!used_ff[mp_ff]) begin
                     ent_we    = 1'b1;
                     val_we    = 1'b1;
                     link_we   = 1'b1;
                     used_set  = 1'b1;
                     used_idx  = mp_ff;
                     status_in = STATUS_OK;
                  end else begin
                     fr_in    = free_ff;
                     addr_in  = LW'(mp_ff);
                     state_in = ST_SRD;
                  end
               end
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (q_key == key_ff) begin
               hit_in   = cur_idx;
               state_in = ST_FIN;
               case (func_ff)
                  FUNC_GET: begin
                     status_in = STATUS_OK;
                     vout_in   = q_val64[DATA_W-1:0];
                  end
                  FUNC_SET: begin
                     val_we    = 1'b1;
                     ent_addr  = cur_idx;
                     status_in = STATUS_OK;
                  end
                  FUNC_DEL: begin
                     status_in = STATUS_OK;
                     if (prev_ff != END_LINK) begin
                        link_we   = 1'b1;
                        link_addr = prev_ff[IDXW-1:0];
                        link_data = q_link;
                        used_clr  = 1'b1;
                     end else if (q_link != END_LINK) begin
                        addr_in  = q_link;
                        state_in = ST_DRD;
                     end else begin
                        used_clr = 1'b1;
                     end
                  end
                  default: begin
                     status_in = STATUS_MISS;
                  end
               endcase
            end else begin
               prev_in  = addr_ff;
               addr_in  = q_link;
               state_in = ST_RD;
            end
         end
         ST_DRD: begin
            state_in = ST_DCPY;
         end
         ST_DCPY: begin
            // refill the head from its successor
            ent_we    = 1'b1;
            val_we    = 1'b1;
            link_we   = 1'b1;
            ent_addr  = hit_ff;
            link_addr = hit_ff;
            ent_key   = q_key;
            ent_home  = q_home;
            ent_val   = q_val;
            link_data = q_link;
            used_clr  = 1'b1;
            status_in = STATUS_OK;
            state_in  = ST_FIN;
         end
         ST_SRD: begin
            state_in = ST_SMP;
         end
         ST_SMP: begin
            ent_we    = 1'b1;
            val_we    = 1'b1;
            link_we   = 1'b1;
            ent_addr  = fr_ff;
            link_addr = fr_ff;
            link_data = q_link;
            used_set  = 1'b1;
            used_idx  = fr_ff;
            if (q_home == mp_ff) begin
               state_in = ST_SLNK;
            end else begin
               // move the foreign entry out to the free slot
               ent_key  = q_key;
               ent_home = q_home;
               ent_val  = q_val;
               addr_in  = LW'(q_home);
               state_in = ST_WRD;
            end
         end
         ST_SLNK: begin
            link_we   = 1'b1;
            link_data = LW'(fr_ff);
            status_in = STATUS_OK;
            state_in  = ST_FIN;
         end
         ST_WRD: begin
            state_in = ST_WCMP;
         end
         ST_WCMP: begin
            if (q_link == END_LINK || q_link == LW'(mp_ff)) begin
               if (q_link == LW'(mp_ff)) begin
                  link_we   = 1'b1;
                  link_addr = cur_idx;
                  link_data = LW'(fr_ff);
               end
               state_in = ST_SMPW;
            end else begin
               addr_in  = q_link;
               state_in = ST_WRD;
            end
         end
         ST_SMPW: begin
            ent_we    = 1'b1;
            val_we    = 1'b1;
            link_we   = 1'b1;
            status_in = STATUS_OK;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = vout_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      used_in = used_ff;
      if (used_set) begin
         used_in[used_idx] = 1'b1;
      end
      if (used_clr) begin
         used_in[used_idx] = 1'b0;
      end
   end

   // slot memories, registered read at the current address
   always_ff @(posedge clock) begin
      if (ent_we) begin
         key_mem[ent_addr]  <= ent_key;
         home_mem[ent_addr] <= ent_home;
      end
      if (val_we) begin
         val_mem[ent_addr] <= ent_val;
      end
      if (link_we) begin
         link_mem[link_addr] <= link_data;
      end
      q_key  <= key_mem[cur_idx];
      q_val  <= val_mem[cur_idx];
      q_home <= home_mem[cur_idx];
      q_link <= link_mem[cur_idx];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      mp_ff         <= mp_in;
      addr_ff       <= addr_in;
      prev_ff       <= prev_in;
      hit_ff        <= hit_in;
      fr_ff         <= fr_in;
      r_ff          <= r_in;
      cnt_ff        <= cnt_in;
      status_ff     <= status_in;
      vout_ff       <= vout_in;
      free_ff       <= free_in;
      full_ff       <= full_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
endmodule
`default_nettype wire

FILE: design/cht_checker.sv
// Port checker for the coalesced hash table unit, bound to the top level.
`default_nettype none
module cht_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [cht_pkg::STATUS_W-1:0] rsp_status,
   input logic [cht_pkg::DATA_W-1:0]   rsp_value_out
);
   import cht_pkg::*;

   // a value comes back only with a found key
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_value_out == '0)
      else $error("value_out nonzero without a hit");

   // status code three is never produced
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != STATUS_BAD)
      else $error("illegal status");

   // an accepted word closes the input until it is processed
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after accept");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_value_out))
      else $error("stalled result changed");
endmodule

bind coalesced_hash_table_unit cht_checker u_cht_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_value_out (rsp_value_out)
);
`default_nettype wire
